@@ sv/crcs_pkg.sv @@
`default_nettype none
package crcs_pkg;

    localparam int COORD_BITS   = 24;
    localparam int T_FRAC_BITS  = 16;
    localparam int MAX_SAMPLES  = 64;

    localparam int T_STEP_W     = T_FRAC_BITS + 1;
    localparam int T_W          = T_FRAC_BITS + 2;
    localparam int CF_W         = COORD_BITS + 4;
    localparam int H_W          = COORD_BITS + T_FRAC_BITS + 6;
    localparam int HH_W         = H_W - T_FRAC_BITS;
    localparam int PH_W         = HH_W + T_FRAC_BITS + 1;

    localparam logic [T_STEP_W-1:0] T_STEP_RESET = T_STEP_W'(3277);
    localparam logic [T_STEP_W-1:0] MIN_STEP =
        T_STEP_W'(((1 << T_FRAC_BITS) + MAX_SAMPLES - 1) / MAX_SAMPLES);
    localparam logic [T_W-1:0] T_ONE = T_W'(1 << T_FRAC_BITS);

    localparam logic [1:0] SEL_B  = 2'd0;
    localparam logic [1:0] SEL_A  = 2'd1;
    localparam logic [1:0] SEL_P1 = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       gen;
        logic       mul;
        logic       acc;
        logic [1:0] sel;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

endpackage
`default_nettype wire

@@ sv/crcs_ctrl.sv @@
`default_nettype none
module crcs_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            s_start_curve,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output crcs_pkg::cmd_t       cmd,
    input  wire crcs_pkg::status_t status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] held_reg, held_next;
    logic       ov_reg, ov_next;
    logic [1:0] held_eff;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = ov_reg;
    assign held_eff = s_start_curve ? 2'd0 : held_reg;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        held_next  = held_reg;
        ov_next    = ov_reg & ~m_ready;
        cmd        = '0;
        cmd.sel    = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    held_next  = (held_eff == 2'd3) ? 2'd3 : held_eff + 2'd1;
                    if (held_eff == 2'd3) begin
                        cmd.gen    = 1'b1;
                        k_next     = crcs_pkg::SEL_B;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (k_reg == crcs_pkg::SEL_P1) begin
                    state_next = ST_EMIT;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_EMIT: begin
                if (!ov_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    ov_next    = 1'b1;
                    k_next     = crcs_pkg::SEL_B;
                    state_next = status.last ? ST_IDLE : ST_MUL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= crcs_pkg::SEL_B;
            held_reg  <= 2'd0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            held_reg  <= held_next;
            ov_reg    <= ov_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/crcs_datapath.sv @@
`default_nettype none
module crcs_datapath (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      cfg_we,
    input  wire logic [crcs_pkg::T_STEP_W-1:0]             cfg_wdata,
    input  wire logic signed [crcs_pkg::COORD_BITS-1:0]    p_in [3],
    output logic signed [crcs_pkg::COORD_BITS-1:0]         s_out [3],
    output logic                                           last_out,
    input  wire crcs_pkg::cmd_t                            cmd,
    output crcs_pkg::status_t                              status
);

    localparam int C  = crcs_pkg::COORD_BITS;
    localparam int F  = crcs_pkg::T_FRAC_BITS;
    localparam int CW = crcs_pkg::CF_W;
    localparam int HW = crcs_pkg::H_W;
    localparam int HHW = crcs_pkg::HH_W;
    localparam int PHW = crcs_pkg::PH_W;
    localparam int TW = crcs_pkg::T_W;

    localparam logic signed [HW:0] ROUND_OUT = (HW+1)'(1 << F);
    localparam logic signed [HW:0] SAT_MAX   = (HW+1)'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [HW:0] SAT_MIN   = -SAT_MAX - (HW+1)'(1);

    logic [crcs_pkg::T_STEP_W-1:0] t_step_reg;
    logic [TW-1:0]                 t_reg;
    logic [TW-1:0]                 t_sum;
    logic [crcs_pkg::T_STEP_W-1:0] step_eff;

    logic signed [C-1:0]   win_reg [3][3];
    logic signed [CW-1:0]  a_reg [3], b_reg [3], c_reg [3], p1_reg [3];
    logic signed [CW-1:0]  a_new [3], b_new [3], c_new [3];
    logic signed [HW-1:0]  h_reg [3];
    logic signed [PHW-1:0] ph_reg [3];
    logic [F-1:0]          pl_reg [3];
    logic signed [PHW-1:0] ph_new [3];
    logic [F-1:0]          pl_new [3];
    logic signed [HW-1:0]  h_acc [3];
    logic signed [C-1:0]   s_res [3];
    logic                  last_reg;
    logic signed [C-1:0]   s_reg [3];

    assign step_eff   = (t_step_reg < crcs_pkg::MIN_STEP) ? crcs_pkg::MIN_STEP : t_step_reg;
    assign t_sum      = t_reg + TW'(step_eff);
    assign status.last = (t_sum >= crcs_pkg::T_ONE);
    assign last_out   = last_reg;

    for (genvar i = 0; i < 3; i++) begin : g_axis
        logic signed [CW-1:0]  w0, w1, w2, p3;
        logic signed [HHW-1:0] hh;
        logic [F-1:0]          hl;
        logic signed [F:0]     ts;
        logic [2*F:0]          lo_prod;
        logic signed [CW-1:0]  kc;
        logic signed [HW+1:0]  acc_sum;
        logic signed [HW:0]    r;

        assign w0 = CW'(win_reg[i][0]);
        assign w1 = CW'(win_reg[i][1]);
        assign w2 = CW'(win_reg[i][2]);
        assign p3 = CW'(p_in[i]);
        assign a_new[i] = w2 - w0;
        assign b_new[i] = (w0 <<< 1) - (w1 <<< 2) - w1 + (w2 <<< 2) - p3;
        assign c_new[i] = p3 - w0 + (w1 <<< 1) + w1 - (w2 <<< 1) - w2;

        assign hh = h_reg[i][HW-1:F];
        assign hl = h_reg[i][F-1:0];
        assign ts = $signed({1'b0, t_reg[F-1:0]});
        assign ph_new[i] = PHW'(hh) * PHW'(ts);
        assign lo_prod = (2*F+1)'(hl) * (2*F+1)'(t_reg[F-1:0])
                       + (2*F+1)'(1 << (F - 1));
        assign pl_new[i] = lo_prod[2*F-1:F];

        always_comb begin
            unique case (cmd.sel)
                crcs_pkg::SEL_B:  kc = b_reg[i];
                crcs_pkg::SEL_A:  kc = a_reg[i];
                crcs_pkg::SEL_P1: kc = p1_reg[i] <<< 1;
                default:          kc = '0;
            endcase
        end
        assign acc_sum  = $signed({(HW+2-F)'(kc), {F{1'b0}}})
                        + (HW+2)'(ph_reg[i]) + (HW+2)'($signed({1'b0, pl_reg[i]}));
        assign h_acc[i] = acc_sum[HW-1:0];

        assign r = ((HW+1)'(h_reg[i]) + ROUND_OUT) >>> (F + 1);
        always_comb begin
            priority if (r > SAT_MAX) begin
                s_res[i] = SAT_MAX[C-1:0];
            end else if (r < SAT_MIN) begin
                s_res[i] = SAT_MIN[C-1:0];
            end else begin
                s_res[i] = r[C-1:0];
            end
        end

        assign s_out[i] = s_reg[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_step_reg <= crcs_pkg::T_STEP_RESET;
        end else if (cfg_we) begin
            t_step_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.gen) begin
            t_reg <= '0;
        end else if (cmd.emit) begin
            t_reg <= t_sum;
        end
        if (cmd.emit) begin
            last_reg <= status.last;
        end
        for (int i = 0; i < 3; i++) begin
            if (cmd.accept) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
                win_reg[i][2] <= p_in[i];
            end
            if (cmd.gen) begin
                a_reg[i]  <= a_new[i];
                b_reg[i]  <= b_new[i];
                c_reg[i]  <= c_new[i];
                p1_reg[i] <= CW'(win_reg[i][1]);
                h_reg[i]  <= HW'(c_new[i]);
            end else if (cmd.acc) begin
                h_reg[i]  <= h_acc[i];
            end else if (cmd.emit) begin
                h_reg[i]  <= HW'(c_reg[i]);
            end
            if (cmd.mul) begin
                ph_reg[i] <= ph_new[i];
                pl_reg[i] <= pl_new[i];
            end
            if (cmd.emit) begin
                s_reg[i] <= s_res[i];
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/catmull_rom_curve_sampler.sv @@
`default_nettype none
// After a point that closes a segment is accepted, each sample takes three multiply/accumulate
// passes of the shared Horner unit plus the output load, which waits while the output register
// is full and m_ready is low; the input is held until the point's last sample is loaded.
// A point that yields no sample is taken and the input stays ready; the output register lets the next
// point be accepted while the last sample waits.
// Reset: synchronous active-low aresetn empties the window, drops pending output and
// restores t_step to its default.
module catmull_rom_curve_sampler (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_we,
    input  wire logic [crcs_pkg::T_STEP_W-1:0]          cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [crcs_pkg::COORD_BITS-1:0] s_px,
    input  wire logic signed [crcs_pkg::COORD_BITS-1:0] s_py,
    input  wire logic signed [crcs_pkg::COORD_BITS-1:0] s_pz,
    input  wire logic                                   s_start_curve,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [crcs_pkg::COORD_BITS-1:0]      m_sx,
    output logic signed [crcs_pkg::COORD_BITS-1:0]      m_sy,
    output logic signed [crcs_pkg::COORD_BITS-1:0]      m_sz,
    output logic                                        m_last_sample
);

    crcs_pkg::cmd_t    cmd;
    crcs_pkg::status_t status;
    logic signed [crcs_pkg::COORD_BITS-1:0] p_in [3];
    logic signed [crcs_pkg::COORD_BITS-1:0] s_out [3];

    assign p_in[0] = s_px;
    assign p_in[1] = s_py;
    assign p_in[2] = s_pz;
    assign m_sx = s_out[0];
    assign m_sy = s_out[1];
    assign m_sz = s_out[2];

    crcs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_curve (s_start_curve),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .cmd           (cmd),
        .status        (status)
    );

    crcs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .p_in      (p_in),
        .s_out     (s_out),
        .last_out  (m_last_sample),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire
